FILE: rtl/ascii_to_integer_parser_unit_defines.svh
// Assertion macros for the ASCII-to-integer parser unit.
// Used by the top level only; relies on i_clk and i_rst_n being in scope.
`ifndef ASCII_TO_INTEGER_PARSER_UNIT_DEFINES_SVH
`define ASCII_TO_INTEGER_PARSER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ATIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ATIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/atip_pkg.sv
// Package for the ASCII-to-integer parser unit: widths, character codes,
// parse phases, register indexes and the digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atip_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = 16;
    localparam int RADIX_BITS  = 6;
    localparam int CH_BITS     = 8;
    localparam int PROD_BITS   = VALUE_BITS + RADIX_BITS + 1;
    localparam int RESULT_BITS = VALUE_BITS + 2 + POS_BITS;
    localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PADDR_W     = 3;

    localparam logic [VALUE_BITS:0] LIMIT_UNSIGNED = {1'b0, {VALUE_BITS{1'b1}}};
    localparam logic [VALUE_BITS:0] LIMIT_NEG      = (VALUE_BITS + 1)'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS:0] LIMIT_POS      = LIMIT_NEG - (VALUE_BITS + 1)'(1);

    localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = RADIX_BITS'(0);
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = RADIX_BITS'(8);
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = RADIX_BITS'(16);
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = RADIX_DEC;

    localparam logic [CH_BITS-1:0] CH_NUL        = 8'h00;
    localparam logic [CH_BITS-1:0] CH_TAB        = 8'h09;
    localparam logic [CH_BITS-1:0] CH_CR         = 8'h0D;
    localparam logic [CH_BITS-1:0] CH_SPACE      = 8'h20;
    localparam logic [CH_BITS-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_ZERO       = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE       = 8'h39;
    localparam logic [CH_BITS-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CH_BITS-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CH_BITS-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CH_BITS-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CH_BITS-1:0] CH_UPPER_X    = 8'h58;
    localparam logic [CH_BITS-1:0] CH_LOWER_X    = 8'h78;
    localparam logic [CH_BITS-1:0] UPPER_BIAS    = CH_UPPER_A - 8'd10;
    localparam logic [CH_BITS-1:0] LOWER_BIAS    = CH_LOWER_A - 8'd10;
    localparam logic [CH_BITS-1:0] NOT_A_DIGIT   = 8'hFF;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_UMODE = 1'b1;

    typedef enum logic [2:0] {
        PH_SKIP     = 3'd0,
        PH_FIRST    = 3'd1,
        PH_ZERO     = 3'd2,
        PH_HEXFIRST = 3'd3,
        PH_DIGITS   = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    // Digit value of a character, NOT_A_DIGIT for anything else
    function automatic logic [CH_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
        logic [CH_BITS-1:0] d;
        d = NOT_A_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = c - UPPER_BIAS;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = c - LOWER_BIAS;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ascii_to_integer_parser_unit.sv
// ASCII-to-integer parser unit, top level: input register, parse step,
// result register and APB register bank. Depends on atip_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none

// Streaming strtol/strtoul: one beat carries one byte of a NUL-terminated
// string. Leading whitespace is skipped, an optional sign taken, a 0x/0X
// prefix recognized for radix 0 or 16, and radix 0 picks octal on a
// leading zero, else decimal. Each string yields exactly one result beat,
// at the first byte that does not extend the number; bytes after it are
// dropped up to and including the NUL. Overflow saturates (signed max/min
// or all ones) and sets range_error. Throughput is one byte per cycle:
// while the input is not stalled: each byte passes the input register,
// then one 32x6 multiply-add and a limit compare update the accumulator
// and, for a byte that ends the number, load the result register. The
// input side stalls only while the result register is still full and the
// byte now held would produce another result. Radix is latched at the
// first significant byte; unsigned_mode is sampled at every digit and at
// the result. Registers: 0x0 radix (6 bits, reset 10), 0x4 unsigned_mode
// (1 bit, reset 0); write them only while the block is idle.

`include "ascii_to_integer_parser_unit_defines.svh"

module ascii_to_integer_parser_unit
    import atip_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input byte stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [CH_BITS-1:0]     s_axis_tdata,   // [7:0] ch
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // value, digits_found, range_error, end_offset, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // ---------------- configuration registers ----------------
    logic [RADIX_BITS-1:0] r_radix;
    logic                  r_umode;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_umode <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_RADIX) begin
                r_radix <= pwdata[RADIX_BITS-1:0];
            end else begin
                r_umode <= pwdata[0];
            end
        end
    end

    // Readback decoded on the register index bit only
    always_comb begin
        unique case (paddr[2])
            REG_RADIX: prdata = 32'(r_radix);
            REG_UMODE: prdata = 32'(r_umode);
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic               r_in_valid;
    logic [CH_BITS-1:0] r_in_ch;
    logic               proc;       // byte in input register is consumed this cycle
    logic               ended;      // that byte ends the number
    logic               out_free;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign proc          = r_in_valid && (!ended || out_free);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ch <= s_axis_tdata;
        end
    end

    // ---------------- parse state ----------------
    t_phase                r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_have, n_have;
    logic                  r_ovf, n_ovf;
    logic [RADIX_BITS-1:0] r_act_radix, n_act_radix;
    logic [POS_BITS-1:0]   r_pos, n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_have      <= 1'b0;
            r_ovf       <= 1'b0;
            r_act_radix <= '0;
            r_pos       <= '0;
        end else if (proc) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_have      <= n_have;
            r_ovf       <= n_ovf;
            r_act_radix <= n_act_radix;
            r_pos       <= n_pos;
        end
    end

    // ---------------- digit datapath ----------------
    logic                  is_ws;
    logic                  is_x;
    logic                  fb_zero;     // first significant byte is a radix-prefix zero
    logic [RADIX_BITS-1:0] fb_radix;
    logic [RADIX_BITS-1:0] step_base;
    logic [CH_BITS-1:0]    dig;
    logic                  dig_ok;
    logic [VALUE_BITS:0]   limit;
    logic [PROD_BITS-1:0]  prod;
    logic                  ovf_now;

    assign is_ws   = (r_in_ch == CH_SPACE) || (r_in_ch >= CH_TAB && r_in_ch <= CH_CR);
    assign is_x    = (r_in_ch == CH_LOWER_X) || (r_in_ch == CH_UPPER_X);
    assign fb_zero = (r_in_ch == CH_ZERO) && (r_radix == RADIX_AUTO || r_radix == RADIX_HEX);

    always_comb begin
        if (fb_zero) begin
            fb_radix = (r_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
        end else begin
            fb_radix = (r_radix == RADIX_AUTO) ? RADIX_DEC : r_radix;
        end
    end

    // In the skip and first-byte phases the base is derived from the register
    assign step_base = (r_phase == PH_SKIP || r_phase == PH_FIRST) ? fb_radix : r_act_radix;
    assign dig       = digit_of(r_in_ch);
    assign dig_ok    = dig < CH_BITS'(step_base);

    always_comb begin
        if (r_umode) begin
            limit = LIMIT_UNSIGNED;
        end else begin
            limit = r_neg ? LIMIT_NEG : LIMIT_POS;
        end
    end

    // acc*base+digit > limit is the overflow test; no division needed
    assign prod    = PROD_BITS'(r_acc) * PROD_BITS'(step_base) + PROD_BITS'(dig);
    assign ovf_now = prod > PROD_BITS'(limit);

    // ---------------- next state ----------------
    logic take_digit;   // accumulate dig this step

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_have      = r_have;
        n_ovf       = r_ovf;
        n_act_radix = r_act_radix;
        n_pos       = (r_pos != POS_MAX) ? r_pos + POS_BITS'(1) : r_pos;
        ended       = 1'b0;
        take_digit  = 1'b0;

        unique case (r_phase)
            PH_SKIP, PH_FIRST: begin
                if (r_phase == PH_SKIP && is_ws) begin
                    // hold, whitespace
                end else if (r_phase == PH_SKIP && r_in_ch == CH_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_FIRST;
                end else if (r_phase == PH_SKIP && r_in_ch == CH_PLUS) begin
                    n_phase = PH_FIRST;
                end else if (fb_zero) begin
                    n_act_radix = fb_radix;
                    n_phase     = PH_ZERO;
                end else begin
                    n_act_radix = fb_radix;
                    if (dig_ok) begin
                        take_digit = 1'b1;
                        n_phase    = PH_DIGITS;
                    end else begin
                        ended = 1'b1;
                    end
                end
            end
            PH_ZERO: begin
                if (is_x) begin
                    n_act_radix = RADIX_HEX;
                    n_phase     = PH_HEXFIRST;
                end else begin
                    // the leading zero counts as a digit; accumulator is still zero
                    n_have = 1'b1;
                    if (dig_ok) begin
                        take_digit = 1'b1;
                        n_phase    = PH_DIGITS;
                    end else begin
                        ended = 1'b1;
                    end
                end
            end
            PH_HEXFIRST, PH_DIGITS: begin
                if (dig_ok) begin
                    take_digit = 1'b1;
                    n_phase    = PH_DIGITS;
                end else begin
                    ended = 1'b1;
                end
            end
            default: begin
                // done: drop bytes until the NUL
                if (r_in_ch == CH_NUL) begin
                    n_phase = PH_SKIP;
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_have  = 1'b0;
                    n_ovf   = 1'b0;
                    n_act_radix = '0;
                    n_pos   = '0;
                end
            end
        endcase

        if (take_digit) begin
            n_have = 1'b1;
            if (!r_ovf) begin
                if (ovf_now) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[VALUE_BITS-1:0];
                end
            end
        end

        if (ended) begin
            if (r_in_ch == CH_NUL) begin
                n_phase     = PH_SKIP;
                n_acc       = '0;
                n_neg       = 1'b0;
                n_have      = 1'b0;
                n_ovf       = 1'b0;
                n_act_radix = '0;
                n_pos       = '0;
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // ---------------- result ----------------
    logic [VALUE_BITS-1:0]  res_value;
    logic                   res_have;
    logic [POS_BITS-1:0]    res_offset;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_valid;

    // On an ending byte the accumulator and overflow flag are unchanged;
    // only digits-found may be set (lone leading zero).
    assign res_have = r_have || (r_phase == PH_ZERO);

    always_comb begin
        if (r_ovf) begin
            if (r_umode) begin
                res_value = LIMIT_UNSIGNED[VALUE_BITS-1:0];
            end else begin
                res_value = r_neg ? LIMIT_NEG[VALUE_BITS-1:0] : LIMIT_POS[VALUE_BITS-1:0];
            end
        end else if (r_neg) begin
            res_value = VALUE_BITS'(0) - r_acc;
        end else begin
            res_value = r_acc;
        end
        if (!res_have) begin
            res_value = '0;
        end
    end

    assign res_offset = res_have ? r_pos : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && ended) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && ended) begin
            r_out_data <= OUT_TDATA_W'({res_offset, r_ovf, res_have, res_value});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    `ATIP_ASSERT(a_ovf_has_digits, r_ovf |-> r_have, "overflow flagged without any digit")
    `ATIP_ASSERT(a_nul_clears, (proc && r_in_ch == CH_NUL) |=> (r_phase == PH_SKIP && r_pos == '0), "NUL did not restart the string")
    `ATIP_ASSERT(a_empty_result, (m_axis_tvalid && !m_axis_tdata[VALUE_BITS]) |-> (m_axis_tdata[VALUE_BITS-1:0] == '0 && !m_axis_tdata[VALUE_BITS+1] && m_axis_tdata[RESULT_BITS-1:VALUE_BITS+2] == '0), "result without digits is not empty")

endmodule

`default_nettype wire

FILE: sim/tb_ascii_to_integer_parser_unit.sv
// Self-checking testbench for ascii_to_integer_parser_unit: streams strings in, checks each
// result beat against a cycle-free parse predictor. Depends on atip_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_ascii_to_integer_parser_unit;
    import atip_pkg::*;

    localparam int SETTLE_CYCLES  = 6;     // byte register plus parse stage, with margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat before giving up

    localparam logic [PADDR_W-1:0] ADDR_RADIX = {REG_RADIX, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UMODE = {REG_UMODE, 2'b00};

    // Result beat layout, value in the lowest bits
    typedef struct packed {
        logic [POS_BITS-1:0]   end_offset;
        logic                  range_error;
        logic                  digits_found;
        logic [VALUE_BITS-1:0] value;
    } t_parse_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CH_BITS-1:0]     s_axis_tdata = '0;      // [7:0] ch
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] value, [32] digits_found, [33] range_error, [49:34] end_offset, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    ascii_to_integer_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [CH_BITS-1:0] text_bytes[$];        // bytes waiting to be sent
    t_parse_result      pending_results[$];   // results predicted, not yet seen
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;

    // Mirror of the register bank and of the string being parsed
    logic [RADIX_BITS-1:0] cfg_radix;
    logic                  cfg_unsigned;
    t_phase                str_phase;
    logic [VALUE_BITS-1:0] str_acc;
    logic                  str_neg;
    logic                  str_has_digits;
    logic                  str_overflow;
    logic [RADIX_BITS-1:0] str_base;
    logic [POS_BITS-1:0]   str_pos;

    // ---------------------------------------------------------------
    // Parse predictor
    // ---------------------------------------------------------------
    function automatic void clear_string();
        str_phase      = PH_SKIP;
        str_acc        = '0;
        str_neg        = 1'b0;
        str_has_digits = 1'b0;
        str_overflow   = 1'b0;
        str_base       = '0;
        str_pos        = '0;
    endfunction

    function automatic int unsigned char_value(input logic [CH_BITS-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return c - CH_UPPER_A + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return c - CH_LOWER_A + 10;
        return 255;
    endfunction

    // Fold one digit in; once the limit is crossed, keep counting digits only
    function automatic void fold_digit(input int unsigned d);
        logic [63:0] base, limit, sum;
        base = (str_base != 0) ? 64'(str_base) : 64'd10;
        str_has_digits = 1'b1;
        if (!str_overflow) begin
            if (cfg_unsigned) limit = 64'hFFFF_FFFF;
            else limit = str_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            sum = str_acc * base + d;
            if (sum > limit) str_overflow = 1'b1;
            else str_acc = sum[VALUE_BITS-1:0];
        end
    endfunction

    function automatic bit fold_if_digit(input logic [CH_BITS-1:0] c);
        int unsigned d, base;
        d = char_value(c);
        base = (str_base != 0) ? str_base : 10;
        if (d >= base) return 1'b0;
        fold_digit(d);
        return 1'b1;
    endfunction

    // First byte after whitespace and sign: latch the base. Returns 1 if it ends the number.
    function automatic bit first_significant(input logic [CH_BITS-1:0] c);
        if (c == CH_ZERO && (cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX)) begin
            str_base  = (cfg_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
            str_phase = PH_ZERO;
            return 1'b0;
        end
        str_base = (cfg_radix == RADIX_AUTO) ? RADIX_DEC : cfg_radix;
        if (fold_if_digit(c)) begin
            str_phase = PH_DIGITS;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void parse_byte(input logic [CH_BITS-1:0] c);
        logic [POS_BITS-1:0] pos_now;
        bit                  ended;
        t_parse_result       res;
        pos_now = str_pos;
        ended   = 1'b0;
        if (str_phase == PH_DONE) begin
            // drop trailing bytes up to the NUL
            if (c == CH_NUL) clear_string();
            else if (str_pos != POS_MAX) str_pos++;
        end else begin
            case (str_phase)
                PH_SKIP: begin
                    if (c == CH_MINUS) begin
                        str_neg   = 1'b1;
                        str_phase = PH_FIRST;
                    end else if (c == CH_PLUS) begin
                        str_phase = PH_FIRST;
                    end else if (c != CH_SPACE && (c < CH_TAB || c > CH_CR)) begin
                        ended = first_significant(c);
                    end
                end
                PH_FIRST: ended = first_significant(c);
                PH_ZERO: begin
                    if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                        str_base  = RADIX_HEX;
                        str_phase = PH_HEXFIRST;
                    end else begin
                        // the lone zero is a digit of its own
                        fold_digit(0);
                        if (fold_if_digit(c)) str_phase = PH_DIGITS;
                        else ended = 1'b1;
                    end
                end
                default: begin
                    if (fold_if_digit(c)) str_phase = PH_DIGITS;
                    else ended = 1'b1;
                end
            endcase
            if (ended) begin
                if (str_overflow) begin
                    if (cfg_unsigned) res.value = '1;
                    else res.value = str_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    res.value = str_neg ? -str_acc : str_acc;
                end
                if (!str_has_digits) res.value = '0;
                res.digits_found = str_has_digits;
                res.range_error  = str_overflow;
                res.end_offset   = str_has_digits ? pos_now : '0;
                pending_results.push_back(res);
                if (c == CH_NUL) begin
                    clear_string();
                end else begin
                    str_phase = PH_DONE;
                    if (str_pos != POS_MAX) str_pos++;
                end
            end else if (str_pos != POS_MAX) begin
                str_pos++;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Byte driver: present the head of the queue, hold it until taken
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        bit taken;
        taken = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(text_bytes.pop_front());
                taken = 1'b1;
            end
            if (!s_axis_tvalid || taken) begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= text_bytes[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: compare each beat with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_parse_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RESULT_BITS-1:0];
            if (pending_results.size() == 0) begin
                $error("result beat with no result pending: %h", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, got.value);
                    error_count++;
                end
                if (got.digits_found !== want.digits_found) begin
                    $error("digits_found: expected %b, got %b",
                           want.digits_found, got.digits_found);
                    error_count++;
                end
                if (got.range_error !== want.range_error) begin
                    $error("range_error: expected %b, got %b",
                           want.range_error, got.range_error);
                    error_count++;
                end
                if (got.end_offset !== want.end_offset) begin
                    $error("end_offset: expected %0d, got %0d",
                           want.end_offset, got.end_offset);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any beat on any port restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Register access and flow control
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // the register takes the data at this edge
        if (addr == ADDR_RADIX) cfg_radix = data[RADIX_BITS-1:0];
        else cfg_unsigned = data[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata at %h: expected %h, got %h", addr, want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold until every byte is taken and every predicted result has come
    task automatic wait_drained();
        while (text_bytes.size() != 0 || pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [RADIX_BITS-1:0] radix, input logic umode);
        wait_drained();
        // a byte that ends nothing may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(ADDR_RADIX, 32'(radix));
        check_reg(ADDR_RADIX, 32'(radix));
        write_reg(ADDR_UMODE, 32'(umode));
        check_reg(ADDR_UMODE, 32'(umode));
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    // ---------------------------------------------------------------
    // String builders
    // ---------------------------------------------------------------
    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endfunction

    function automatic logic [CH_BITS-1:0] digit_char(input int unsigned d);
        if (d < 10) return CH_ZERO + CH_BITS'(d);
        if ($urandom_range(1)) return CH_LOWER_A + CH_BITS'(d - 10);
        return CH_UPPER_A + CH_BITS'(d - 10);
    endfunction

    function automatic void push_number(input logic [63:0] val, input int unsigned base);
        int unsigned digs[$];
        do begin
            digs.push_front(val % base);
            val = val / base;
        end while (val != 0);
        foreach (digs[k]) text_bytes.push_back(digit_char(digs[k]));
    endfunction

    // Optional junk bytes, then the NUL
    function automatic void push_tail();
        int n, i;
        n = $urandom_range(1) ? $urandom_range(1, 4) : 0;
        for (i = 0; i < n; i++) text_bytes.push_back(CH_BITS'($urandom_range(1, 255)));
        text_bytes.push_back(CH_NUL);
    endfunction

    // Well-formed number: whitespace, sign, prefix, digits, terminator
    function automatic void gen_number_string();
        int unsigned ws_n, base, eff, n, pick, i;
        bit          neg;
        logic [63:0] limit, val;
        ws_n = $urandom_range(3);
        for (i = 0; i < ws_n; i++) begin
            pick = $urandom_range(5);
            text_bytes.push_back((pick == 5) ? CH_SPACE : CH_TAB + CH_BITS'(pick));
        end
        pick = $urandom_range(3);
        neg  = (pick == 0);
        if (pick == 0) text_bytes.push_back(CH_MINUS);
        if (pick == 1) text_bytes.push_back(CH_PLUS);
        base = cfg_radix;
        if (cfg_radix == RADIX_AUTO) begin
            pick = $urandom_range(2);
            base = (pick == 0) ? 16 : (pick == 1) ? 8 : 10;
            if (pick != 2) text_bytes.push_back(CH_ZERO);
            if (pick == 0) text_bytes.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
        end else if (cfg_radix == RADIX_HEX && $urandom_range(1)) begin
            text_bytes.push_back(CH_ZERO);
            text_bytes.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
        end
        eff = (base > 36) ? 36 : base;
        if (eff >= 2 && $urandom_range(1)) begin
            // aim at the saturation boundary
            if (cfg_unsigned) limit = 64'hFFFF_FFFF;
            else limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            case ($urandom_range(4))
                0: val = limit;
                1: val = limit + 1;
                2: val = limit - 1;
                3: val = 64'($urandom);
                default: val = 64'($urandom_range(999));
            endcase
            push_number(val, eff);
        end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (i = 0; i < n; i++) text_bytes.push_back(digit_char($urandom_range(eff - 1)));
        end
        push_tail();
    endfunction

    // Sequences that end early: bare signs, empty hex prefix, whitespace only
    function automatic void gen_broken_string();
        case ($urandom_range(5))
            0: push_text("-");
            1: push_text("+-5");
            2: push_text("0x");
            3: push_text("0X");
            4: push_text("0xg");
            default: push_text(" \t ");
        endcase
        push_tail();
    endfunction

    function automatic void gen_noise_string();
        int n, i;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) text_bytes.push_back(CH_BITS'($urandom_range(255)));
        text_bytes.push_back(CH_NUL);
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int          radix_plan[12] = '{10, 0, 16, 8, 2, 36, 1, 63, 37, 16, 0, 10};
        int          i, start_len, sent;
        int unsigned kind;

        cfg_radix    = RADIX_RESET;
        cfg_unsigned = 1'b0;
        clear_string();
        set_idle(0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of the register bank
        check_reg(ADDR_RADIX, 32'(RADIX_RESET));
        check_reg(ADDR_UMODE, 32'd0);

        // Directed strings, decimal signed from reset
        text_bytes.push_back(CH_TAB);
        push_text("+7");
        text_bytes.push_back(CH_NUL);
        text_bytes.push_back(CH_CR);
        push_text("-0z9");                 // 'z' ends it, '9' is dropped
        text_bytes.push_back(CH_NUL);
        push_text("+");                    // sign with no digits
        text_bytes.push_back(CH_NUL);
        text_bytes.push_back(8'hFF);
        text_bytes.push_back(CH_NUL);
        push_text("-2147483649");          // saturates to the signed minimum
        text_bytes.push_back(CH_NUL);
        // Change registers mid-string: base stays latched, unsigned applies to the rest
        push_text(" -12");
        set_config(RADIX_AUTO, 1'b1);
        push_text("3");
        text_bytes.push_back(CH_NUL);
        push_text("0x");                   // hex prefix with no hex digit
        text_bytes.push_back(CH_NUL);
        push_text("0");                    // lone zero under auto radix
        text_bytes.push_back(CH_NUL);

        // Random phases over register settings and idle patterns
        for (i = 0; i < 12; i++) begin
            set_config(RADIX_BITS'(radix_plan[i]), i[0]);
            set_idle(i % 4);
            sent = 0;
            while (sent < 60) begin
                start_len = text_bytes.size();
                kind = $urandom_range(99);
                if (kind < 70) gen_number_string();
                else if (kind < 85) gen_broken_string();
                else gen_noise_string();
                sent += text_bytes.size() - start_len;
                // now and then let the pipe run dry
                if ($urandom_range(14) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/atip_pkg.sv
rtl/ascii_to_integer_parser_unit.sv
sim/tb_ascii_to_integer_parser_unit.sv
